>>> sv/dcim_pkg.sv
// Shared types and constants of the calorimeter channel id mapper.
package dcim_pkg;

	localparam logic [1:0] FN_ABS2REL = 2'd0;
	localparam logic [1:0] FN_REL2ABS = 2'd1;
	localparam logic [1:0] FN_POS2ID  = 2'd2;
	localparam logic [1:0] FN_UNUSED  = 2'd3;

	localparam logic [2:0] REG_NUM_MODULES  = 3'd0;
	localparam logic [2:0] REG_CRYSTALS_PHI = 3'd1;
	localparam logic [2:0] REG_CRYSTALS_Z   = 3'd2;
	localparam logic [2:0] REG_PADS_PHI     = 3'd3;
	localparam logic [2:0] REG_PADS_Z       = 3'd4;
	localparam logic [2:0] REG_CELL_PITCH   = 3'd5;

	localparam logic signed [24:0] ABS_MAX = 25'sd524287;

	// Geometry figures derived from the configuration registers.
	typedef struct packed {
		logic [15:0] cper;
		logic [16:0] pper;
		logic [7:0]  ncz;
		logic [7:0]  npz;
		logic [19:0] call;
		logic [21:0] tot;
	} geo_t;

	// Everything an item carries down the pipeline.
	typedef struct packed {
		logic [1:0]         func;
		logic [18:0]        abs_id;
		logic [3:0]         mod;
		logic               pad;
		logic [8:0]         row;
		logic [7:0]         col;
		logic signed [18:0] x;
		logic signed [18:0] z;
		logic signed [22:0] pa;
		logic signed [17:0] pb;
		logic signed [24:0] id1;
		logic [24:0]        rem_r;
		logic [24:0]        rem_c;
		logic               pos_r;
		logic               pos_c;
		logic               sat_r;
		logic               sat_c;
		logic [7:0]         q_r;
		logic [7:0]         q_c;
		logic [7:0]         row2;
		logic [7:0]         col2;
		logic signed [24:0] id;
		logic               err;
		logic               spad;
		logic [18:0]        rem;
		logic [3:0]         modq;
		logic [8:0]         rowq;
	} item_t;

	typedef struct packed {
		logic [18:0] abs_out;
		logic [3:0]  module_out;
		logic        is_pad_out;
		logic [8:0]  row_out;
		logic [7:0]  column_out;
		logic        error;
	} res_t;

endpackage

>>> sv/dcim_split.sv
// Range check and split of an absolute id into module, row and column.
module dcim_split import dcim_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  geo_t  geo,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  out_valid,
	input  logic  out_ready,
	output item_t out_item
);

	logic v_s9, v_s10, v_s11, v_s12, v_s13, v_s14;
	logic en_s9, en_s10, en_s11, en_s12, en_s13, en_s14;
	item_t it_s9, it_s10, it_s11, it_s12, it_s13, it_s14;
	item_t nx9, nx10, nx11, nx12, nx13, nx14;
	logic [16:0] per;
	logic [16:0] ncol;

	// One restoring division step: quotient bit on top, new remainder below.
	function automatic logic [19:0] dstep(logic [18:0] rem, logic [16:0] d, int unsigned sh);
		logic [20:0] t;
		t = 21'({4'b0, d} << sh);
		if ({2'b0, rem} >= t)
			return {1'b1, rem - t[18:0]};
		return {1'b0, rem};
	endfunction

	assign en_s14 = !v_s14 || out_ready;
	assign en_s13 = !v_s13 || en_s14;
	assign en_s12 = !v_s12 || en_s13;
	assign en_s11 = !v_s11 || en_s12;
	assign en_s10 = !v_s10 || en_s11;
	assign en_s9  = !v_s9 || en_s10;
	assign in_ready  = en_s9;
	assign out_valid = v_s14;
	assign out_item  = it_s14;

	always_comb begin
		nx9 = in_item;
		nx9.err = (in_item.func != FN_ABS2REL && in_item.func != FN_REL2ABS &&
			in_item.func != FN_POS2ID) || in_item.id < 25'sd1 ||
			in_item.id > $signed({3'b0, geo.tot}) || in_item.id > ABS_MAX;
		nx9.spad = in_item.id > $signed({5'b0, geo.call});
		if (nx9.spad)
			nx9.rem = 19'(in_item.id - $signed({5'b0, geo.call}) - 25'sd1);
		else
			nx9.rem = 19'(in_item.id - 25'sd1);
		nx9.modq = '0;
		nx9.rowq = '0;
	end

	assign per  = it_s9.spad ? geo.pper : {1'b0, geo.cper};
	assign ncol = {9'b0, (it_s11.spad ? geo.npz : geo.ncz)};

	always_comb begin
		nx10 = it_s9;
		{nx10.modq[3], nx10.rem} = dstep(nx10.rem, per, 3);
		{nx10.modq[2], nx10.rem} = dstep(nx10.rem, per, 2);
	end

	always_comb begin
		logic [16:0] p;
		nx11 = it_s10;
		p = it_s10.spad ? geo.pper : {1'b0, geo.cper};
		{nx11.modq[1], nx11.rem} = dstep(nx11.rem, p, 1);
		{nx11.modq[0], nx11.rem} = dstep(nx11.rem, p, 0);
	end

	always_comb begin
		nx12 = it_s11;
		{nx12.rowq[8], nx12.rem} = dstep(nx12.rem, ncol, 8);
		{nx12.rowq[7], nx12.rem} = dstep(nx12.rem, ncol, 7);
		{nx12.rowq[6], nx12.rem} = dstep(nx12.rem, ncol, 6);
	end

	always_comb begin
		logic [16:0] c;
		nx13 = it_s12;
		c = {9'b0, (it_s12.spad ? geo.npz : geo.ncz)};
		{nx13.rowq[5], nx13.rem} = dstep(nx13.rem, c, 5);
		{nx13.rowq[4], nx13.rem} = dstep(nx13.rem, c, 4);
		{nx13.rowq[3], nx13.rem} = dstep(nx13.rem, c, 3);
	end

	always_comb begin
		logic [16:0] c;
		nx14 = it_s13;
		c = {9'b0, (it_s13.spad ? geo.npz : geo.ncz)};
		{nx14.rowq[2], nx14.rem} = dstep(nx14.rem, c, 2);
		{nx14.rowq[1], nx14.rem} = dstep(nx14.rem, c, 1);
		{nx14.rowq[0], nx14.rem} = dstep(nx14.rem, c, 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
		end else begin
			if (en_s9)  v_s9  <= in_valid;
			if (en_s10) v_s10 <= v_s9;
			if (en_s11) v_s11 <= v_s10;
			if (en_s12) v_s12 <= v_s11;
			if (en_s13) v_s13 <= v_s12;
			if (en_s14) v_s14 <= v_s13;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s9)  it_s9  <= nx9;
		if (en_s10) it_s10 <= nx10;
		if (en_s11) it_s11 <= nx11;
		if (en_s12) it_s12 <= nx12;
		if (en_s13) it_s13 <= nx13;
		if (en_s14) it_s14 <= nx14;
	end

`ifndef ASSERT_OFF
	a_mod_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s14 && !out_ready |=> v_s14 && $stable(it_s14))
		else $error("split output changed while stalled");
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		v_s13 && !en_s13 |=> v_s13)
		else $error("item lost in split pipeline");
	a_rem_row: assert property (@(posedge clk) disable iff (!arst_n)
		v_s14 && !it_s14.err |-> {1'b0, it_s14.rem[7:0]} <
			{1'b0, (it_s14.spad ? geo.npz : geo.ncz)})
		else $error("column remainder out of range");
`endif

endmodule

>>> sv/detector_channel_id_mapper.sv
// Top level of the calorimeter channel id mapper: registers and main pipeline.
// Items pass in order through stages s1 to s8, split stages s9 to s14 and stage s15.
// Throughput: one item per cycle unless stalled; the fifteen register stages each
// hold one item and advance independently, so a stalled output only fills the empty stages.
// Reset clears all valid bits and loads the geometry registers with
// 5 modules, 64 x 56 crystals, 128 x 60 pads and a pitch of 576 (2.25 cm).
module detector_channel_id_mapper import dcim_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic [1:0]         func,
	input  logic [18:0]        abs_id,
	input  logic [3:0]         module_in,
	input  logic               is_pad_in,
	input  logic [8:0]         row_in,
	input  logic [7:0]         column_in,
	input  logic signed [18:0] pos_x,
	input  logic signed [18:0] pos_z,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [18:0]        abs_out,
	output logic [3:0]         module_out,
	output logic               is_pad_out,
	output logic [8:0]         row_out,
	output logic [7:0]         column_out,
	output logic               error
);

	logic [3:0]  nmod_q;
	logic [7:0]  cphi_q, cz_q, pz_q;
	logic [8:0]  pphi_q;
	logic [15:0] pitch_q;
	logic [7:0]  cphi1, cz1, pz1;
	logic [8:0]  pphi1;
	logic [15:0] pitch1;
	logic [16:0] dv;
	logic [15:0] cper_q;
	logic [16:0] pper_q;
	logic [23:0] kr_q, kc_q;
	logic [19:0] call_q;
	logic [20:0] ptot_q;
	geo_t geo;
	logic cfg_wr;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s15;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_s15;
	item_t it_s1, it_s2, it_s3, it_s4, it_s5, it_s6, it_s7, it_s8;
	item_t nx1, nx2, nx3, nx4, nx5, nx6, nx7, nx8;
	res_t  res_s15, nx15;
	logic  sp_ready, sp_valid;
	item_t sp_item;

	// One restoring step of the position divider.
	function automatic logic [25:0] pstep(logic [24:0] rem, logic [16:0] d, int unsigned sh);
		logic [24:0] t;
		t = 25'({8'b0, d} << sh);
		if (rem >= t)
			return {1'b1, rem - t};
		return {1'b0, rem};
	endfunction

	// ---------------- configuration ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nmod_q  <= 4'd5;
			cphi_q  <= 8'd64;
			cz_q    <= 8'd56;
			pphi_q  <= 9'd128;
			pz_q    <= 8'd60;
			pitch_q <= 16'd576;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_NUM_MODULES:  nmod_q  <= pwdata[3:0];
				REG_CRYSTALS_PHI: cphi_q  <= pwdata[7:0];
				REG_CRYSTALS_Z:   cz_q    <= pwdata[7:0];
				REG_PADS_PHI:     pphi_q  <= pwdata[8:0];
				REG_PADS_Z:       pz_q    <= pwdata[7:0];
				REG_CELL_PITCH:   pitch_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_NUM_MODULES:  prdata = {28'b0, nmod_q};
			REG_CRYSTALS_PHI: prdata = {24'b0, cphi_q};
			REG_CRYSTALS_Z:   prdata = {24'b0, cz_q};
			REG_PADS_PHI:     prdata = {23'b0, pphi_q};
			REG_PADS_Z:       prdata = {24'b0, pz_q};
			REG_CELL_PITCH:   prdata = {16'b0, pitch_q};
			default:          prdata = '0;
		endcase
	end

	// A zero crystal or pad count or pitch counts as one; the module count is used as written.
	assign cphi1  = (cphi_q == 8'd0) ? 8'd1 : cphi_q;
	assign cz1    = (cz_q == 8'd0) ? 8'd1 : cz_q;
	assign pphi1  = (pphi_q == 9'd0) ? 9'd1 : pphi_q;
	assign pz1    = (pz_q == 8'd0) ? 8'd1 : pz_q;
	assign pitch1 = (pitch_q == 16'd0) ? 16'd1 : pitch_q;
	assign dv     = {pitch1, 1'b0};

	// Registered products, then call_q, ptot_q; the user holds items until they settle.
	always_ff @(posedge clk) begin
		cper_q <= 16'(cphi1) * 16'(cz1);
		pper_q <= 17'(pphi1) * 17'(pz1);
		kr_q   <= 24'(cphi1) * 24'(pitch1);
		kc_q   <= 24'(cz1) * 24'(pitch1);
		call_q <= 20'(nmod_q) * 20'(cper_q);
		ptot_q <= 21'(nmod_q) * 21'(pper_q);
	end

	assign geo.cper = cper_q;
	assign geo.pper = pper_q;
	assign geo.ncz  = cz1;
	assign geo.npz  = pz1;
	assign geo.call = call_q;
	assign geo.tot  = {2'b0, call_q} + {1'b0, ptot_q};

	// ---------------- handshake chain ----------------
	assign en_s15 = !v_s15 || result_ready;
	assign en_s8  = !v_s8 || sp_ready;
	assign en_s7  = !v_s7 || en_s8;
	assign en_s6  = !v_s6 || en_s7;
	assign en_s5  = !v_s5 || en_s6;
	assign en_s4  = !v_s4 || en_s5;
	assign en_s3  = !v_s3 || en_s4;
	assign en_s2  = !v_s2 || en_s3;
	assign en_s1  = !v_s1 || en_s2;
	assign item_ready = en_s1;

	// ---------------- stage logic ----------------
	always_comb begin
		nx1 = '0;
		nx1.func   = func;
		nx1.abs_id = abs_id;
		nx1.mod    = module_in;
		nx1.pad    = is_pad_in;
		nx1.row    = row_in;
		nx1.col    = column_in;
		nx1.x      = pos_x;
		nx1.z      = pos_z;
	end

	always_comb begin
		logic signed [4:0]  mm1;
		logic signed [9:0]  rm1;
		logic [16:0]        perm;
		logic [7:0]         nc;
		logic signed [25:0] mr, mc;
		nx2 = it_s1;
		mm1 = $signed({1'b0, it_s1.mod}) - 5'sd1;
		rm1 = $signed({1'b0, it_s1.row}) - 10'sd1;
		perm = (it_s1.func == FN_REL2ABS && it_s1.pad) ? pper_q : {1'b0, cper_q};
		nc = it_s1.pad ? pz1 : cz1;
		nx2.pa = 23'(mm1) * 23'($signed({1'b0, perm}));
		nx2.pb = 18'(rm1) * 18'($signed({1'b0, nc}));
		// Ceiling division is done as floor((n - 1) / d) + 1 for positive n.
		mr = $signed({{6{it_s1.x[18]}}, it_s1.x, 1'b0}) + $signed({2'b0, kr_q}) - 26'sd1;
		mc = $signed({2'b0, kc_q}) - $signed({{6{it_s1.z[18]}}, it_s1.z, 1'b0}) - 26'sd1;
		nx2.pos_r = !mr[25];
		nx2.pos_c = !mc[25];
		nx2.rem_r = mr[24:0];
		nx2.rem_c = mc[24:0];
	end

	always_comb begin
		logic signed [24:0] off;
		nx3 = it_s2;
		off = (it_s2.func == FN_REL2ABS && it_s2.pad) ? $signed({5'b0, call_q}) : 25'sd0;
		nx3.id1 = 25'(it_s2.pa) + 25'(it_s2.pb) + $signed({17'b0, it_s2.col}) + off;
		nx3.sat_r = it_s2.rem_r >= 25'({8'b0, dv} << 8);
		nx3.sat_c = it_s2.rem_c >= 25'({8'b0, dv} << 8);
		{nx3.q_r[7], nx3.rem_r} = pstep(nx3.rem_r, dv, 7);
		{nx3.q_r[6], nx3.rem_r} = pstep(nx3.rem_r, dv, 6);
		{nx3.q_c[7], nx3.rem_c} = pstep(nx3.rem_c, dv, 7);
		{nx3.q_c[6], nx3.rem_c} = pstep(nx3.rem_c, dv, 6);
	end

	always_comb begin
		nx4 = it_s3;
		{nx4.q_r[5], nx4.rem_r} = pstep(nx4.rem_r, dv, 5);
		{nx4.q_r[4], nx4.rem_r} = pstep(nx4.rem_r, dv, 4);
		{nx4.q_c[5], nx4.rem_c} = pstep(nx4.rem_c, dv, 5);
		{nx4.q_c[4], nx4.rem_c} = pstep(nx4.rem_c, dv, 4);
	end

	always_comb begin
		nx5 = it_s4;
		{nx5.q_r[3], nx5.rem_r} = pstep(nx5.rem_r, dv, 3);
		{nx5.q_r[2], nx5.rem_r} = pstep(nx5.rem_r, dv, 2);
		{nx5.q_c[3], nx5.rem_c} = pstep(nx5.rem_c, dv, 3);
		{nx5.q_c[2], nx5.rem_c} = pstep(nx5.rem_c, dv, 2);
	end

	always_comb begin
		nx6 = it_s5;
		{nx6.q_r[1], nx6.rem_r} = pstep(nx6.rem_r, dv, 1);
		{nx6.q_r[0], nx6.rem_r} = pstep(nx6.rem_r, dv, 0);
		{nx6.q_c[1], nx6.rem_c} = pstep(nx6.rem_c, dv, 1);
		{nx6.q_c[0], nx6.rem_c} = pstep(nx6.rem_c, dv, 0);
	end

	always_comb begin
		logic [8:0] cr, cc;
		logic [7:0] ccl;
		nx7 = it_s6;
		cr = !it_s6.pos_r ? 9'd0 : it_s6.sat_r ? 9'd256 : {1'b0, it_s6.q_r} + 9'd1;
		cc = !it_s6.pos_c ? 9'd0 : it_s6.sat_c ? 9'd256 : {1'b0, it_s6.q_c} + 9'd1;
		if (cr == 9'd0)
			nx7.row2 = 8'd1;
		else if (cr > {1'b0, cphi1})
			nx7.row2 = cphi1;
		else
			nx7.row2 = cr[7:0];
		if (cc == 9'd0)
			ccl = 8'd1;
		else if (cc > {1'b0, cz1})
			ccl = cz1;
		else
			ccl = cc[7:0];
		// The column axis runs against z.
		nx7.col2 = cz1 - ccl + 8'd1;
	end

	always_comb begin
		logic [15:0]        pb2;
		logic signed [24:0] id2;
		nx8 = it_s7;
		pb2 = (16'(it_s7.row2) - 16'd1) * 16'(cz1);
		id2 = 25'(it_s7.pa) + $signed({9'b0, pb2}) + $signed({17'b0, it_s7.col2});
		case (it_s7.func)
			FN_ABS2REL: nx8.id = $signed({6'b0, it_s7.abs_id});
			FN_REL2ABS: nx8.id = it_s7.id1;
			FN_POS2ID:  nx8.id = id2;
			default:    nx8.id = 25'sd0;
		endcase
	end

	dcim_split u_split (
		.clk       (clk),
		.arst_n    (arst_n),
		.geo       (geo),
		.in_valid  (v_s8),
		.in_ready  (sp_ready),
		.in_item   (it_s8),
		.out_valid (sp_valid),
		.out_ready (en_s15),
		.out_item  (sp_item)
	);

	always_comb begin
		nx15 = '0;
		if (sp_item.err) begin
			nx15.error = 1'b1;
		end else if (sp_item.func == FN_REL2ABS) begin
			nx15.abs_out    = sp_item.id[18:0];
			nx15.module_out = sp_item.mod;
			nx15.is_pad_out = sp_item.pad;
			nx15.row_out    = sp_item.row;
			nx15.column_out = sp_item.col;
		end else begin
			nx15.abs_out    = sp_item.id[18:0];
			nx15.module_out = sp_item.modq + 4'd1;
			nx15.is_pad_out = sp_item.spad;
			nx15.row_out    = sp_item.rowq + 9'd1;
			nx15.column_out = sp_item.rem[7:0] + 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s15 <= 1'b0;
		end else begin
			if (en_s1)  v_s1  <= item_valid;
			if (en_s2)  v_s2  <= v_s1;
			if (en_s3)  v_s3  <= v_s2;
			if (en_s4)  v_s4  <= v_s3;
			if (en_s5)  v_s5  <= v_s4;
			if (en_s6)  v_s6  <= v_s5;
			if (en_s7)  v_s7  <= v_s6;
			if (en_s8)  v_s8  <= v_s7;
			if (en_s15) v_s15 <= sp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1)  it_s1   <= nx1;
		if (en_s2)  it_s2   <= nx2;
		if (en_s3)  it_s3   <= nx3;
		if (en_s4)  it_s4   <= nx4;
		if (en_s5)  it_s5   <= nx5;
		if (en_s6)  it_s6   <= nx6;
		if (en_s7)  it_s7   <= nx7;
		if (en_s8)  it_s8   <= nx8;
		if (en_s15) res_s15 <= nx15;
	end

	assign result_valid = v_s15;
	assign abs_out      = res_s15.abs_out;
	assign module_out   = res_s15.module_out;
	assign is_pad_out   = res_s15.is_pad_out;
	assign row_out      = res_s15.row_out;
	assign column_out   = res_s15.column_out;
	assign error        = res_s15.error;

`ifndef ASSERT_OFF
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && error |-> abs_out == 19'd0 && module_out == 4'd0 &&
			!is_pad_out && row_out == 9'd0 && column_out == 8'd0)
		else $error("error result carries nonzero fields");
	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !error |-> abs_out != 19'd0 && {3'b0, abs_out} <= geo.tot)
		else $error("accepted id outside the channel range");
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> v_s1)
		else $error("accepted item missing from first stage");
	a_s8_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 && !sp_ready |=> v_s8 && $stable(it_s8))
		else $error("stalled item changed before the splitter took it");
`endif

endmodule

>>> sim/detector_channel_id_mapper_tb.sv
// Testbench of the calorimeter channel id mapper: fixed and random geometry settings, stalls and id checks.
module detector_channel_id_mapper_tb;
	import dcim_pkg::*;

	typedef struct packed {
		logic [1:0]         func;
		logic [18:0]        abs_id;
		logic [3:0]         mod;
		logic               pad;
		logic [8:0]         row;
		logic [7:0]         col;
		logic signed [18:0] x;
		logic signed [18:0] z;
	} chan_req_t;

	class id_scoreboard;
		longint nmod, cphi, cz, pphi, pz, pitch;
		res_t   pending[$];
		int     fails;

		function new();
			nmod = 5; cphi = 64; cz = 56; pphi = 128; pz = 60; pitch = 576;
			fails = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] v);
			case (idx)
				REG_NUM_MODULES:  nmod = longint'(v[3:0]);
				REG_CRYSTALS_PHI: cphi = longint'(v[7:0]);
				REG_CRYSTALS_Z:   cz = longint'(v[7:0]);
				REG_PADS_PHI:     pphi = longint'(v[8:0]);
				REG_PADS_Z:       pz = longint'(v[7:0]);
				REG_CELL_PITCH:   pitch = longint'(v[15:0]);
				default: ;
			endcase
		endfunction

		function longint one(longint v);
			return (v == 0) ? 1 : v;
		endfunction

		function longint ceil_ratio(longint n, longint d);
			if (n > 0)
				return (n + d - 1) / d;
			return -((-n) / d);
		endfunction

		function longint clamp_cnt(longint v, longint hi);
			if (v < 1)
				return 1;
			return (v > hi) ? hi : v;
		endfunction

		function res_t bad_id();
			res_t r;
			r = '0;
			r.error = 1'b1;
			return r;
		endfunction

		function longint crystals_all();
			return nmod * one(cphi) * one(cz);
		endfunction

		function longint id_total();
			return crystals_all() + nmod * one(pphi) * one(pz);
		endfunction

		function res_t split_id(longint id);
			res_t   r;
			longint per, ncol, rest, m, rr, rw;
			r = '0;
			if (id < 1 || id > id_total() || id > 524287)
				return bad_id();
			if (id <= crystals_all()) begin
				ncol = one(cz);
				per = one(cphi) * ncol;
				rest = id;
			end else begin
				ncol = one(pz);
				per = one(pphi) * ncol;
				rest = id - crystals_all();
				r.is_pad_out = 1'b1;
			end
			m = (rest - 1) / per + 1;
			rr = rest - (m - 1) * per;
			rw = (rr - 1) / ncol + 1;
			r.abs_out = 19'(id);
			r.module_out = 4'(m);
			r.row_out = 9'(rw);
			r.column_out = 8'(rr - (rw - 1) * ncol);
			return r;
		endfunction

		function res_t map_channel(chan_req_t it);
			res_t   r;
			longint m, nphi, nz, id, pt, xx, zz, rw, cl;
			m = longint'(it.mod);
			nphi = one(cphi);
			nz = one(cz);
			case (it.func)
				FN_ABS2REL: r = split_id(longint'(it.abs_id));
				FN_REL2ABS: begin
					if (!it.pad)
						id = (m - 1) * nphi * nz + (longint'(it.row) - 1) * nz + it.col;
					else
						id = crystals_all() + (m - 1) * one(pphi) * one(pz)
							+ (longint'(it.row) - 1) * one(pz) + it.col;
					if (id < 1 || id > id_total() || id > 524287) begin
						r = bad_id();
					end else begin
						r.abs_out = 19'(id);
						r.module_out = it.mod;
						r.is_pad_out = it.pad;
						r.row_out = it.row;
						r.column_out = it.col;
						r.error = 1'b0;
					end
				end
				FN_POS2ID: begin
					pt = one(pitch);
					xx = longint'(it.x);
					zz = longint'(it.z);
					rw = clamp_cnt(ceil_ratio(2 * xx + nphi * pt, 2 * pt), nphi);
					cl = clamp_cnt(nz + 1 - ceil_ratio(-2 * zz + nz * pt, 2 * pt), nz);
					r = split_id((m - 1) * nphi * nz + (rw - 1) * nz + cl);
				end
				default: r = bad_id();
			endcase
			return r;
		endfunction

		function void note(chan_req_t it);
			pending.push_back(map_channel(it));
		endfunction

		function void cmp(string name, longint e, longint a);
			if (e != a) begin
				$display("%0t mismatch %s: expected %0d actual %0d", $time, name, e, a);
				fails++;
			end
		endfunction

		function void check(res_t got);
			res_t e;
			if (pending.size() == 0) begin
				$display("%0t unexpected result: expected none actual %p", $time, got);
				fails++;
				return;
			end
			e = pending.pop_front();
			cmp("abs_out", e.abs_out, got.abs_out);
			cmp("module_out", e.module_out, got.module_out);
			cmp("is_pad_out", e.is_pad_out, got.is_pad_out);
			cmp("row_out", e.row_out, got.row_out);
			cmp("column_out", e.column_out, got.column_out);
			cmp("error", e.error, got.error);
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               item_valid = 1'b0;
	logic               item_ready;
	logic [1:0]         func = '0;
	logic [18:0]        abs_id = '0;
	logic [3:0]         module_in = '0;
	logic               is_pad_in = 1'b0;
	logic [8:0]         row_in = '0;
	logic [7:0]         column_in = '0;
	logic signed [18:0] pos_x = '0, pos_z = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic [18:0]        abs_out;
	logic [3:0]         module_out;
	logic               is_pad_out;
	logic [8:0]         row_out;
	logic [7:0]         column_out;
	logic               error;

	detector_channel_id_mapper dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	id_scoreboard sb = new();
	chan_req_t    req_q[$];
	int           send_idle = 10, recv_idle = 77;
	longint       cycles = 0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 300000) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Sender: hold the item until accepted, then maybe go idle before the next one.
	always @(posedge clk) begin
		chan_req_t nx;
		if (item_valid && item_ready) begin
			sb.note({func, abs_id, module_in, is_pad_in, row_in, column_in, pos_x, pos_z});
			void'(req_q.pop_front());
		end
		if (item_valid && !item_ready) begin
			item_valid <= 1'b1;
		end else if (req_q.size() > 0 && arst_n && $urandom_range(99) >= send_idle) begin
			nx = req_q[0];
			item_valid <= 1'b1;
			{func, abs_id, module_in, is_pad_in, row_in, column_in, pos_x, pos_z} <= nx;
		end else begin
			item_valid <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (result_valid && result_ready)
			sb.check({abs_out, module_out, is_pad_out, row_out, column_out, error});
		result_ready <= arst_n && ($urandom_range(99) >= recv_idle);
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 5'(idx) << 2; pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.set_reg(idx, v);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic drain();
		while (req_q.size() > 0 || item_valid || sb.pending.size() > 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic geometry(int nm, int a, int b, int c, int d, int p);
		reg_write(REG_NUM_MODULES, nm);
		reg_write(REG_CRYSTALS_PHI, a);
		reg_write(REG_CRYSTALS_Z, b);
		reg_write(REG_PADS_PHI, c);
		reg_write(REG_PADS_Z, d);
		reg_write(REG_CELL_PITCH, p);
	endtask

	task automatic push(logic [1:0] f, int a, int m, bit p, int r, int c, int x, int z);
		chan_req_t it;
		it.func = f; it.abs_id = 19'(a); it.mod = 4'(m); it.pad = p;
		it.row = 9'(r); it.col = 8'(c); it.x = 19'(x); it.z = 19'(z);
		req_q.push_back(it);
	endtask

	task automatic random_items(int n);
		chan_req_t it;
		longint    tot, pt;
		for (int i = 0; i < n; i++) begin
			it = 81'({$urandom, $urandom, $urandom});
			tot = sb.id_total();
			pt = sb.one(sb.pitch);
			it.func = ($urandom_range(19) == 0) ? FN_UNUSED : 2'($urandom_range(2));
			if ($urandom_range(9) > 1)
				it.abs_id = 19'($urandom_range(tot + 2 > 524287 ? 524287 : tot + 2));
			if ($urandom_range(9) > 1) begin
				it.mod = 4'($urandom_range(sb.nmod + 1));
				it.row = 9'($urandom_range(it.pad ? sb.one(sb.pphi) + 1
					: sb.one(sb.cphi) + 1));
				it.col = 8'($urandom_range(it.pad ? sb.one(sb.pz) + 1 : sb.one(sb.cz) + 1));
			end
			if ($urandom_range(9) > 2) begin
				it.x = 19'($signed($urandom_range(2 * pt * sb.one(sb.cphi)))
					- pt * sb.one(sb.cphi));
				it.z = 19'($signed($urandom_range(2 * pt * sb.one(sb.cz)))
					- pt * sb.one(sb.cz));
			end
			req_q.push_back(it);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		// Directed items under the reset geometry.
		push(FN_ABS2REL, 0, 0, 0, 0, 0, 0, 0);
		push(FN_ABS2REL, 1, 0, 0, 0, 0, 0, 0);
		push(FN_ABS2REL, 17920, 0, 0, 0, 0, 0, 0);
		push(FN_ABS2REL, 17921, 0, 0, 0, 0, 0, 0);
		push(FN_ABS2REL, 56320, 0, 0, 0, 0, 0, 0);
		push(FN_ABS2REL, 56321, 0, 0, 0, 0, 0, 0);
		push(FN_ABS2REL, 524287, 15, 1, 511, 255, -1, -1);
		push(FN_REL2ABS, 0, 1, 0, 1, 1, 0, 0);
		push(FN_REL2ABS, 0, 5, 1, 128, 60, 0, 0);
		push(FN_REL2ABS, 0, 15, 1, 511, 255, 0, 0);
		push(FN_REL2ABS, 0, 0, 0, 0, 0, 0, 0);
		push(FN_REL2ABS, 0, 2, 0, 100, 200, 0, 0);
		push(FN_POS2ID, 0, 1, 0, 0, 0, 0, 0);
		push(FN_POS2ID, 0, 3, 0, 0, 0, 262143, 262143);
		push(FN_POS2ID, 0, 3, 0, 0, 0, -262144, -262144);
		push(FN_POS2ID, 0, 8, 0, 0, 0, 576, -576);
		push(FN_POS2ID, 0, 15, 0, 0, 0, 1, -1);
		push(FN_POS2ID, 0, 0, 0, 0, 0, 0, 0);
		push(FN_UNUSED, 5, 1, 0, 1, 1, 0, 0);
		drain();
		for (int s = 0; s < 6; s++) begin
			send_idle = (s < 2) ? 10 : (s < 4) ? 77 : 0;
			recv_idle = (s < 2) ? 77 : (s < 4) ? 10 : 0;
			case (s)
				0: geometry(1, 1, 1, 1, 1, 1);
				1: geometry(8, 128, 128, 256, 128, 65535);
				2: geometry(0, 0, 0, 0, 0, 0);
				3: geometry($urandom_range(1, 8), $urandom_range(1, 128),
					$urandom_range(1, 128), $urandom_range(1, 256),
					$urandom_range(1, 128), $urandom_range(1, 2000));
				4: geometry(5, 64, 56, 128, 60, 576);
				default: geometry(15, 255, 255, 511, 255, 256);
			endcase
			random_items(55);
			drain();
			random_items(55);
			drain();
		end
		if (sb.fails == 0 && sb.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
